>>> design/ogrc_pkg.sv
`default_nettype none

package ogrc_pkg;

  // Field and port widths fixed by the interface.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam int CRD_W  = 16;
  localparam int DIM_W  = 9;
  localparam int VAL_W  = 8;
  localparam int ERR_W  = 12;

  // Request modes.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_RAY   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SENSOR_X   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SENSOR_Y   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FREE       = 3'd4;
  localparam logic [CFG_IW-1:0] REG_OCCUPIED   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_UNKNOWN    = 3'd6;

  // Result kinds selected by the controller.
  localparam logic [1:0] RES_ZERO    = 2'd0;
  localparam logic [1:0] RES_OUTSIDE = 2'd1;
  localparam logic [1:0] RES_READ    = 2'd2;
  localparam logic [1:0] RES_RAY     = 2'd3;

  // Active map geometry and cell bytes, already clamped.
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] y0;
    logic [VAL_W-1:0] pass_val;
    logic [VAL_W-1:0] occ_val;
    logic [VAL_W-1:0] unk_val;
  } ogrc_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       clr_step;
    logic       clr_unknown;
    logic       mul_sensor;
    logic       mul_target;
    logic       trace;
    logic       wr_occ;
    logic       finish;
    logic [1:0] res_sel;
  } ogrc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_map;
    logic clr_last;
    logic trace_done;
  } ogrc_sts_t;

endpackage

`default_nettype wire

>>> design/occupancy_grid_ray_cast.sv
// Ray request: traces sensor to target, one cell per cycle, then marks the target occupied.
// Read returns the target byte; clear writes the unknown byte to each cell, one per cycle.
// Target outside the map, or unused mode: result on the cycle after the accept.
// One request at a time; busy stays high until the result strobe. Results cannot be stalled.
// Reset (rst_n low, synchronous) starts a fill pass that writes 255 to every cell; busy is
// high meanwhile and configuration writes are still taken.
`default_nettype none

module occupancy_grid_ray_cast #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         in_mode,
  input  wire logic signed [ogrc_pkg::CRD_W-1:0]  in_cell_x,
  input  wire logic signed [ogrc_pkg::CRD_W-1:0]  in_cell_y,
  output logic                                    out_strobe,
  output logic                                    out_status,
  output logic [ogrc_pkg::VAL_W-1:0]              out_cell_value,
  output logic [ogrc_pkg::DIM_W-1:0]              out_cells_visited,
  input  wire logic                               cfg_we,
  input  wire logic [ogrc_pkg::CFG_IW-1:0]        cfg_index,
  input  wire logic [ogrc_pkg::CFG_DW-1:0]        cfg_data
);

  ogrc_pkg::ogrc_cfg_t cfg;
  ogrc_pkg::ogrc_cmd_t cmd;
  ogrc_pkg::ogrc_sts_t sts;

  ogrc_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ogrc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_mode),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  ogrc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .cfg               (cfg),
    .cmd               (cmd),
    .sts               (sts),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_cell_value    (out_cell_value),
    .out_cells_visited (out_cells_visited)
  );

endmodule

`default_nettype wire

>>> design/ogrc_cfg.sv
`default_nettype none

module ogrc_cfg #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ogrc_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [ogrc_pkg::CFG_DW-1:0]   cfg_data,
  output ogrc_pkg::ogrc_cfg_t                cfg
);

  logic [ogrc_pkg::DIM_W-1:0]        map_width_r;
  logic [ogrc_pkg::DIM_W-1:0]        map_height_r;
  logic signed [ogrc_pkg::CRD_W-1:0] sensor_x_r;
  logic signed [ogrc_pkg::CRD_W-1:0] sensor_y_r;
  logic [ogrc_pkg::VAL_W-1:0]        free_r;
  logic [ogrc_pkg::VAL_W-1:0]        occ_r;
  logic [ogrc_pkg::VAL_W-1:0]        unk_r;

  logic [ogrc_pkg::DIM_W-1:0]        w_act;
  logic [ogrc_pkg::DIM_W-1:0]        h_act;
  logic [ogrc_pkg::DIM_W-1:0]        wm1;
  logic [ogrc_pkg::DIM_W-1:0]        hm1;

  // Register file, written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
      sensor_x_r   <= '0;
      sensor_y_r   <= '0;
      free_r       <= 8'd255;
      occ_r        <= 8'd0;
      unk_r        <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        ogrc_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_data[ogrc_pkg::DIM_W-1:0];
        ogrc_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_data[ogrc_pkg::DIM_W-1:0];
        ogrc_pkg::REG_SENSOR_X:   sensor_x_r   <= $signed(cfg_data);
        ogrc_pkg::REG_SENSOR_Y:   sensor_y_r   <= $signed(cfg_data);
        ogrc_pkg::REG_FREE:       free_r       <= cfg_data[ogrc_pkg::VAL_W-1:0];
        ogrc_pkg::REG_OCCUPIED:   occ_r        <= cfg_data[ogrc_pkg::VAL_W-1:0];
        ogrc_pkg::REG_UNKNOWN:    unk_r        <= cfg_data[ogrc_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the map size into one cell up to the store's size.
  always_comb begin
    if (map_width_r == '0) begin
      w_act = 9'd1;
    end else if (32'(map_width_r) > MAX_WIDTH) begin
      w_act = 9'(MAX_WIDTH);
    end else begin
      w_act = map_width_r;
    end
    if (map_height_r == '0) begin
      h_act = 9'd1;
    end else if (32'(map_height_r) > MAX_HEIGHT) begin
      h_act = 9'(MAX_HEIGHT);
    end else begin
      h_act = map_height_r;
    end
    wm1 = w_act - 9'd1;
    hm1 = h_act - 9'd1;
  end

  // Clamp the sensor cell into the active map.
  always_comb begin
    if (sensor_x_r < 0) begin
      cfg.x0 = '0;
    end else if (sensor_x_r > $signed({7'b0, wm1})) begin
      cfg.x0 = wm1;
    end else begin
      cfg.x0 = sensor_x_r[ogrc_pkg::DIM_W-1:0];
    end
    if (sensor_y_r < 0) begin
      cfg.y0 = '0;
    end else if (sensor_y_r > $signed({7'b0, hm1})) begin
      cfg.y0 = hm1;
    end else begin
      cfg.y0 = sensor_y_r[ogrc_pkg::DIM_W-1:0];
    end
    cfg.w        = w_act;
    cfg.h        = h_act;
    cfg.pass_val = free_r;
    cfg.occ_val  = occ_r;
    cfg.unk_val  = unk_r;
  end

endmodule

`default_nettype wire

>>> design/ogrc_ctrl.sv
`default_nettype none

module ogrc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        mode,
  input  ogrc_pkg::ogrc_sts_t    sts,
  output logic                   busy,
  output ogrc_pkg::ogrc_cmd_t    cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLEAR  = 4'd2;
  localparam logic [3:0] S_MULS   = 4'd3;
  localparam logic [3:0] S_MULT   = 4'd4;
  localparam logic [3:0] S_TRACE  = 4'd5;
  localparam logic [3:0] S_TAIL   = 4'd6;
  localparam logic [3:0] S_ENDW   = 4'd7;
  localparam logic [3:0] S_RDREQ  = 4'd8;
  localparam logic [3:0] S_RDDONE = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       ray_r;
  logic       ray_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ray_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ray_r   <= ray_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    ray_nxt   = ray_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        // Fill the store with the reset byte after reset.
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (mode)
            ogrc_pkg::MODE_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            ogrc_pkg::MODE_RAY: begin
              ray_nxt = 1'b1;
              if (sts.in_map) begin
                state_nxt = S_MULS;
              end else begin
                cmd.finish  = 1'b1;
                cmd.res_sel = ogrc_pkg::RES_OUTSIDE;
              end
            end
            ogrc_pkg::MODE_READ: begin
              ray_nxt = 1'b0;
              if (sts.in_map) begin
                state_nxt = S_MULT;
              end else begin
                cmd.finish  = 1'b1;
                cmd.res_sel = ogrc_pkg::RES_OUTSIDE;
              end
            end
            default: begin
              cmd.finish  = 1'b1;
              cmd.res_sel = ogrc_pkg::RES_ZERO;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step    = 1'b1;
        cmd.clr_unknown = 1'b1;
        if (sts.clr_last) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = ogrc_pkg::RES_ZERO;
          state_nxt   = S_IDLE;
        end
      end
      S_MULS: begin
        cmd.mul_sensor = 1'b1;
        state_nxt      = S_MULT;
      end
      S_MULT: begin
        cmd.mul_target = 1'b1;
        state_nxt      = ray_r ? S_TRACE : S_RDREQ;
      end
      S_TRACE: begin
        cmd.trace = 1'b1;
        if (sts.trace_done) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        // The last traced cell finishes its free write here.
        state_nxt = S_ENDW;
      end
      S_ENDW: begin
        cmd.wr_occ  = 1'b1;
        cmd.finish  = 1'b1;
        cmd.res_sel = ogrc_pkg::RES_RAY;
        state_nxt   = S_IDLE;
      end
      S_RDREQ: begin
        state_nxt = S_RDDONE;
      end
      S_RDDONE: begin
        cmd.finish  = 1'b1;
        cmd.res_sel = ogrc_pkg::RES_READ;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/ogrc_dp.sv
`default_nettype none

module ogrc_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic signed [ogrc_pkg::CRD_W-1:0]  in_cell_x,
  input  wire logic signed [ogrc_pkg::CRD_W-1:0]  in_cell_y,
  input  ogrc_pkg::ogrc_cfg_t                     cfg,
  input  ogrc_pkg::ogrc_cmd_t                     cmd,
  output ogrc_pkg::ogrc_sts_t                     sts,
  output logic                                    out_strobe,
  output logic                                    out_status,
  output logic [ogrc_pkg::VAL_W-1:0]              out_cell_value,
  output logic [ogrc_pkg::DIM_W-1:0]              out_cells_visited
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = ogrc_pkg::DIM_W;
  localparam int EW    = ogrc_pkg::ERR_W;

  // Occupancy store.
  logic [ogrc_pkg::VAL_W-1:0] mem [CELLS];
  logic [ogrc_pkg::VAL_W-1:0] rdata_r;
  logic [AW-1:0]              raddr;
  logic [AW-1:0]              waddr;
  logic [ogrc_pkg::VAL_W-1:0] wdata;
  logic                       we;

  // Ray and sweep state.
  logic [AW-1:0]              clr_cnt_r;
  logic [DW-1:0]              x_r;
  logic [DW-1:0]              y_r;
  logic [DW-1:0]              tx_r;
  logic [DW-1:0]              ty_r;
  logic [DW-1:0]              dx_r;
  logic [DW-1:0]              dy_r;
  logic                       sx_pos_r;
  logic                       sy_pos_r;
  logic signed [EW-1:0]       err_r;
  logic [AW-1:0]              base_r;
  logic [AW-1:0]              tidx_r;
  logic [DW-1:0]              visited_r;
  logic [AW-1:0]              wa_r;
  logic                       pend_r;

  logic [DW-1:0]              dx_init;
  logic [DW-1:0]              dy_init;
  logic [DW-1:0]              row;
  logic [2*DW-1:0]            prod;
  logic [AW-1:0]              cur_addr;
  logic signed [EW:0]         e2;
  logic signed [EW:0]         dx_s;
  logic signed [EW:0]         dy_s;
  logic signed [EW-1:0]       err_step;
  logic                       step_x;
  logic                       step_y;
  logic [DW-1:0]              visited_inc;

  // Requested cell inside the active map.
  assign sts.in_map = !in_cell_x[ogrc_pkg::CRD_W-1] && !in_cell_y[ogrc_pkg::CRD_W-1]
                      && (in_cell_x < $signed({7'b0, cfg.w}))
                      && (in_cell_y < $signed({7'b0, cfg.h}));

  assign sts.clr_last = (clr_cnt_r == AW'(CELLS - 1));

  // Row offset multiplier, shared by the sensor and target setup steps.
  assign row  = cmd.mul_sensor ? (cfg.h - 9'd1 - y_r) : (cfg.h - 9'd1 - ty_r);
  assign prod = row * cfg.w;

  // Bresenham step decision for the current cell.
  assign cur_addr    = AW'(x_r) + base_r;
  assign e2          = {err_r, 1'b0};
  assign dx_s        = $signed({{(EW + 1 - DW){1'b0}}, dx_r});
  assign dy_s        = $signed({{(EW + 1 - DW){1'b0}}, dy_r});
  assign step_x      = (e2 >= -dy_s);
  assign step_y      = (e2 <= dx_s);
  assign visited_inc = visited_r + 9'd1;
  assign sts.trace_done = ((x_r == tx_r) && (y_r == ty_r)) || (visited_inc == 9'h1FF);

  always_comb begin
    err_step = err_r;
    if (step_x) begin
      err_step = err_step - $signed({{(EW - DW){1'b0}}, dy_r});
    end
    if (step_y) begin
      err_step = err_step + $signed({{(EW - DW){1'b0}}, dx_r});
    end
  end

  assign dx_init = (x_r < tx_r) ? (tx_r - x_r) : (x_r - tx_r);
  assign dy_init = (y_r < ty_r) ? (ty_r - y_r) : (y_r - ty_r);

  // Sweep counter for reset fill and clear requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + AW'(1);
    end
  end

  // Pending free write for the cell read in the previous cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.trace;
    end
  end

  // Ray setup and walk.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r       <= cfg.x0;
      y_r       <= cfg.y0;
      tx_r      <= in_cell_x[DW-1:0];
      ty_r      <= in_cell_y[DW-1:0];
      visited_r <= '0;
    end
    if (cmd.mul_sensor) begin
      base_r   <= AW'(prod);
      dx_r     <= dx_init;
      dy_r     <= dy_init;
      sx_pos_r <= (x_r < tx_r);
      sy_pos_r <= (y_r < ty_r);
      err_r    <= $signed({{(EW - DW){1'b0}}, dx_init})
                  - $signed({{(EW - DW){1'b0}}, dy_init});
    end
    if (cmd.mul_target) begin
      tidx_r <= AW'(tx_r) + AW'(prod);
    end
    if (cmd.trace) begin
      wa_r      <= cur_addr;
      visited_r <= visited_inc;
      err_r     <= err_step;
      if (step_x) begin
        x_r <= sx_pos_r ? x_r + 9'd1 : x_r - 9'd1;
      end
      if (step_y) begin
        y_r    <= sy_pos_r ? y_r + 9'd1 : y_r - 9'd1;
        base_r <= sy_pos_r ? base_r - AW'(cfg.w) : base_r + AW'(cfg.w);
      end
    end
  end

  // Write port selection; the sources never overlap in time.
  always_comb begin
    we    = 1'b0;
    waddr = tidx_r;
    wdata = cfg.occ_val;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = cmd.clr_unknown ? cfg.unk_val : 8'hFF;
    end else if (pend_r) begin
      we    = (rdata_r != cfg.occ_val);
      waddr = wa_r;
      wdata = cfg.pass_val;
    end else if (cmd.wr_occ) begin
      we    = 1'b1;
      waddr = tidx_r;
      wdata = cfg.occ_val;
    end
  end

  assign raddr = cmd.trace ? cur_addr : tidx_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Result register, shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd.res_sel)
        ogrc_pkg::RES_OUTSIDE: begin
          out_status        <= 1'b1;
          out_cell_value    <= '0;
          out_cells_visited <= '0;
        end
        ogrc_pkg::RES_READ: begin
          out_status        <= 1'b0;
          out_cell_value    <= rdata_r;
          out_cells_visited <= '0;
        end
        ogrc_pkg::RES_RAY: begin
          out_status        <= 1'b0;
          out_cell_value    <= '0;
          out_cells_visited <= visited_r;
        end
        default: begin
          out_status        <= 1'b0;
          out_cell_value    <= '0;
          out_cells_visited <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_occupancy_grid_ray_cast.sv
`timescale 1ns / 1ps

module tb_occupancy_grid_ray_cast;

  localparam int GRID_MAX_W = 256;
  localparam int GRID_MAX_H = 256;
  localparam int GRID_CELLS = GRID_MAX_W * GRID_MAX_H;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;

  typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct packed {
    step_kind_t                        kind;
    logic [1:0]                        mode;
    logic signed [ogrc_pkg::CRD_W-1:0] x;
    logic signed [ogrc_pkg::CRD_W-1:0] y;
    logic [ogrc_pkg::CFG_IW-1:0]       idx;
    logic [ogrc_pkg::CFG_DW-1:0]       data;
  } step_t;

  typedef struct packed {
    logic                       status;
    logic [ogrc_pkg::VAL_W-1:0] cell_value;
    logic [ogrc_pkg::DIM_W-1:0] visited;
  } cell_result_t;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = ogrc_pkg::MODE_CLEAR;
  logic signed [ogrc_pkg::CRD_W-1:0] in_cell_x = '0;
  logic signed [ogrc_pkg::CRD_W-1:0] in_cell_y = '0;
  logic out_strobe;
  logic out_status;
  logic [ogrc_pkg::VAL_W-1:0] out_cell_value;
  logic [ogrc_pkg::DIM_W-1:0] out_cells_visited;
  logic cfg_we = 1'b0;
  logic [ogrc_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [ogrc_pkg::CFG_DW-1:0] cfg_data = '0;

  // Shadow copy of the grid and its registers.
  logic [ogrc_pkg::VAL_W-1:0] map_store [0:GRID_CELLS-1];
  logic [ogrc_pkg::DIM_W-1:0] grid_w = 9'd256;
  logic [ogrc_pkg::DIM_W-1:0] grid_h = 9'd256;
  logic signed [ogrc_pkg::CRD_W-1:0] sensor_x = '0;
  logic signed [ogrc_pkg::CRD_W-1:0] sensor_y = '0;
  logic [ogrc_pkg::VAL_W-1:0] free_byte = 8'd255;
  logic [ogrc_pkg::VAL_W-1:0] occ_byte = 8'd0;
  logic [ogrc_pkg::VAL_W-1:0] unknown_byte = 8'd255;

  step_t request_queue [$];
  cell_result_t awaited_results [$];
  int err_count = 0;
  int gap_left = 0;
  int gap_pct = 20;
  int issued = 0;
  int plan_w = GRID_MAX_W;
  int plan_h = GRID_MAX_H;

  occupancy_grid_ray_cast #(
    .MAX_WIDTH (GRID_MAX_W),
    .MAX_HEIGHT(GRID_MAX_H)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_cell_value   (out_cell_value),
    .out_cells_visited(out_cells_visited),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Flipped-row image order: row 0 is stored last.
  function automatic int grid_addr(int x, int y, int w, int h);
    return clamp_int(x + (h - 1 - y) * w, 0, GRID_CELLS - 1);
  endfunction

  task automatic write_shadow_reg(logic [ogrc_pkg::CFG_IW-1:0] idx,
                                  logic [ogrc_pkg::CFG_DW-1:0] data);
    case (idx)
      ogrc_pkg::REG_MAP_WIDTH:  grid_w = data[ogrc_pkg::DIM_W-1:0];
      ogrc_pkg::REG_MAP_HEIGHT: grid_h = data[ogrc_pkg::DIM_W-1:0];
      ogrc_pkg::REG_SENSOR_X:   sensor_x = data;
      ogrc_pkg::REG_SENSOR_Y:   sensor_y = data;
      ogrc_pkg::REG_FREE:       free_byte = data[ogrc_pkg::VAL_W-1:0];
      ogrc_pkg::REG_OCCUPIED:   occ_byte = data[ogrc_pkg::VAL_W-1:0];
      ogrc_pkg::REG_UNKNOWN:    unknown_byte = data[ogrc_pkg::VAL_W-1:0];
      default: ;
    endcase
  endtask

  // Applies one request to the shadow grid and returns the result it must produce.
  function automatic cell_result_t grid_outcome(logic [1:0] mode,
                                                logic signed [ogrc_pkg::CRD_W-1:0] tx16,
                                                logic signed [ogrc_pkg::CRD_W-1:0] ty16);
    cell_result_t r;
    int w, h, tx, ty, x, y, dx, dy, sx, sy, err, e2, steps, a, i;
    bit in_map, done;
    r = '0;
    w = clamp_int(int'(grid_w), 1, GRID_MAX_W);
    h = clamp_int(int'(grid_h), 1, GRID_MAX_H);
    tx = tx16;
    ty = ty16;
    in_map = (tx >= 0) && (tx < w) && (ty >= 0) && (ty < h);
    case (mode)
      ogrc_pkg::MODE_CLEAR: begin
        for (i = 0; i < GRID_CELLS; i++) map_store[i] = unknown_byte;
      end
      ogrc_pkg::MODE_RAY: begin
        if (!in_map) begin
          r.status = 1'b1;
        end else begin
          x = clamp_int(int'(sensor_x), 0, w - 1);
          y = clamp_int(int'(sensor_y), 0, h - 1);
          dx = (tx > x) ? tx - x : x - tx;
          sx = (x < tx) ? 1 : -1;
          dy = (ty > y) ? y - ty : ty - y;
          sy = (y < ty) ? 1 : -1;
          err = dx + dy;
          steps = 0;
          done = 1'b0;
          // Bresenham walk; occupied cells keep their byte.
          while (!done) begin
            a = grid_addr(x, y, w, h);
            if (map_store[a] != occ_byte) map_store[a] = free_byte;
            steps++;
            if ((x == tx && y == ty) || steps >= 511) begin
              done = 1'b1;
            end else begin
              e2 = 2 * err;
              if (e2 >= dy) begin
                err += dy;
                x += sx;
              end
              if (e2 <= dx) begin
                err += dx;
                y += sy;
              end
            end
          end
          map_store[grid_addr(tx, ty, w, h)] = occ_byte;
          r.visited = ogrc_pkg::DIM_W'(steps);
        end
      end
      ogrc_pkg::MODE_READ: begin
        if (!in_map) r.status = 1'b1;
        else r.cell_value = map_store[grid_addr(tx, ty, w, h)];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_req(logic [1:0] m, int x, int y);
    step_t s;
    s = '0;
    s.kind = STEP_REQ;
    s.mode = m;
    s.x = ogrc_pkg::CRD_W'(x);
    s.y = ogrc_pkg::CRD_W'(y);
    request_queue.insert(request_queue.size(), s);
  endtask

  task automatic add_cfg(logic [ogrc_pkg::CFG_IW-1:0] idx, logic [ogrc_pkg::CFG_DW-1:0] data);
    step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.idx = idx;
    s.data = data;
    request_queue.insert(request_queue.size(), s);
    if (idx == ogrc_pkg::REG_MAP_WIDTH)
      plan_w = clamp_int(int'(data[ogrc_pkg::DIM_W-1:0]), 1, GRID_MAX_W);
    if (idx == ogrc_pkg::REG_MAP_HEIGHT)
      plan_h = clamp_int(int'(data[ogrc_pkg::DIM_W-1:0]), 1, GRID_MAX_H);
  endtask

  task automatic add_drain();
    step_t s;
    s = '0;
    s.kind = STEP_DRAIN;
    request_queue.insert(request_queue.size(), s);
  endtask

  task automatic report_diff(string field, int want, int got);
    err_count++;
    if (err_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
  endtask

  // Driver: presents queued requests, writes registers only when the block is idle.
  always @(posedge clk) begin : drive
    step_t nx;
    logic taken, idle;
    logic s_nx, we_nx;
    logic [1:0] mode_nx;
    logic signed [ogrc_pkg::CRD_W-1:0] x_nx, y_nx;
    logic [ogrc_pkg::CFG_IW-1:0] idx_nx;
    logic [ogrc_pkg::CFG_DW-1:0] data_nx;
    cell_result_t res;
    s_nx = start;
    we_nx = 1'b0;
    mode_nx = in_mode;
    x_nx = in_cell_x;
    y_nx = in_cell_y;
    idx_nx = cfg_index;
    data_nx = cfg_data;
    if (rst_n) begin
      taken = start && (busy === 1'b0);
      if (taken) begin
        res = grid_outcome(in_mode, in_cell_x, in_cell_y);
        awaited_results.insert(awaited_results.size(), res);
        s_nx = 1'b0;
      end
      // A result strobe this cycle means the monitor is still consuming one.
      idle = !taken && !start && (busy === 1'b0) && (out_strobe !== 1'b1) &&
             (awaited_results.size() == 0);
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0) begin
          nx = request_queue[0];
          case (nx.kind)
            STEP_REQ: begin
              s_nx = 1'b1;
              mode_nx = nx.mode;
              x_nx = nx.x;
              y_nx = nx.y;
              void'(request_queue.pop_front());
              issued++;
              if (issued % 100 == 0)
                gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
              // No idling over the tail of the run.
              if (request_queue.size() > 150 && $urandom_range(0, 99) < gap_pct)
                gap_left = $urandom_range(1, 16);
            end
            STEP_CFG: begin
              if (idle) begin
                we_nx = 1'b1;
                idx_nx = nx.idx;
                data_nx = nx.data;
                write_shadow_reg(nx.idx, nx.data);
                void'(request_queue.pop_front());
                // Let the registered map geometry settle before the next request.
                gap_left = 2;
              end
            end
            default: begin
              if (idle) void'(request_queue.pop_front());
            end
          endcase
        end
      end
    end
    start <= s_nx;
    in_mode <= mode_nx;
    in_cell_x <= x_nx;
    in_cell_y <= y_nx;
    cfg_we <= we_nx;
    cfg_index <= idx_nx;
    cfg_data <= data_nx;
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin : watch
    cell_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (awaited_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status)
          report_diff("status", want.status, out_status);
        if (out_cell_value !== want.cell_value)
          report_diff("cell_value", want.cell_value, out_cell_value);
        if (out_cells_visited !== want.visited)
          report_diff("cells_visited", want.visited, out_cells_visited);
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int random_items, phase, shape, n_items, k, pick, w_raw, h_raw, sxv, syv, tx, ty;
    logic [ogrc_pkg::VAL_W-1:0] free_raw;
    for (int i = 0; i < GRID_CELLS; i++) map_store[i] = 8'd255;

    // Directed part on a small 8 x 6 map.
    add_cfg(ogrc_pkg::REG_MAP_WIDTH, 16'd8);
    add_cfg(ogrc_pkg::REG_MAP_HEIGHT, 16'd6);
    add_cfg(ogrc_pkg::REG_SENSOR_X, 16'd2);
    add_cfg(ogrc_pkg::REG_SENSOR_Y, 16'd3);
    add_cfg(ogrc_pkg::REG_FREE, 16'h005A);
    add_cfg(ogrc_pkg::REG_OCCUPIED, 16'h00C3);
    add_cfg(ogrc_pkg::REG_UNKNOWN, 16'h0081);
    add_req(ogrc_pkg::MODE_READ, 0, 0);
    add_req(ogrc_pkg::MODE_RAY, 7, 5);
    add_req(ogrc_pkg::MODE_RAY, 0, 0);
    add_req(ogrc_pkg::MODE_RAY, 2, 3);
    add_req(ogrc_pkg::MODE_RAY, 7, 0);
    add_req(ogrc_pkg::MODE_RAY, -1, 2);
    add_req(ogrc_pkg::MODE_RAY, 8, 2);
    add_req(ogrc_pkg::MODE_RAY, 3, 6);
    add_req(ogrc_pkg::MODE_RAY, -32768, 32767);
    add_req(ogrc_pkg::MODE_READ, 7, 5);
    add_req(ogrc_pkg::MODE_READ, 4, 4);
    add_req(ogrc_pkg::MODE_READ, 32767, -32768);
    add_req(MODE_UNUSED, 5, 5);
    add_req(ogrc_pkg::MODE_READ, -1, -1);
    // Sensor far outside the map gets clamped to a corner.
    add_cfg(ogrc_pkg::REG_SENSOR_X, 16'hFED4);
    add_cfg(ogrc_pkg::REG_SENSOR_Y, 16'h7FFF);
    add_req(ogrc_pkg::MODE_RAY, 7, 0);
    // Sizes out of range: width 0 becomes 1, height 511 becomes 256.
    add_cfg(ogrc_pkg::REG_MAP_WIDTH, 16'd0);
    add_cfg(ogrc_pkg::REG_MAP_HEIGHT, 16'd511);
    add_req(ogrc_pkg::MODE_RAY, 0, 255);
    add_req(ogrc_pkg::MODE_RAY, 0, 0);
    add_req(ogrc_pkg::MODE_READ, 0, 100);
    // Full map with the longest rays.
    add_cfg(ogrc_pkg::REG_MAP_WIDTH, 16'd300);
    add_cfg(ogrc_pkg::REG_MAP_HEIGHT, 16'd256);
    add_cfg(ogrc_pkg::REG_SENSOR_X, 16'd0);
    add_cfg(ogrc_pkg::REG_SENSOR_Y, 16'd0);
    add_req(ogrc_pkg::MODE_RAY, 255, 255);
    add_req(ogrc_pkg::MODE_RAY, 255, 0);
    // Shrinking the map reads old bytes through the new index formula.
    add_cfg(ogrc_pkg::REG_MAP_WIDTH, 16'd8);
    add_cfg(ogrc_pkg::REG_MAP_HEIGHT, 16'd6);
    add_req(ogrc_pkg::MODE_READ, 7, 5);
    add_req(ogrc_pkg::MODE_READ, 0, 0);
    // Free and occupied bytes equal.
    add_cfg(ogrc_pkg::REG_FREE, 16'h003C);
    add_cfg(ogrc_pkg::REG_OCCUPIED, 16'h003C);
    add_req(ogrc_pkg::MODE_RAY, 5, 1);
    add_req(ogrc_pkg::MODE_READ, 5, 1);
    add_req(ogrc_pkg::MODE_CLEAR, 0, 0);
    add_req(ogrc_pkg::MODE_READ, 3, 3);
    add_drain();

    // Random phases, each with fresh register settings.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        w_raw = $urandom_range(200, 511);
        h_raw = $urandom_range(200, 511);
        n_items = 15;
      end else if (shape == 1) begin
        w_raw = $urandom_range(0, 1);
        h_raw = $urandom_range(0, 40);
        n_items = 40;
      end else if (shape == 2) begin
        w_raw = $urandom_range(0, 40);
        h_raw = $urandom_range(0, 1);
        n_items = 40;
      end else begin
        w_raw = $urandom_range(1, 24);
        h_raw = $urandom_range(1, 24);
        n_items = $urandom_range(50, 110);
      end
      add_cfg(ogrc_pkg::REG_MAP_WIDTH, {7'($urandom), 9'(w_raw)});
      add_cfg(ogrc_pkg::REG_MAP_HEIGHT, {7'($urandom), 9'(h_raw)});
      sxv = ($urandom_range(0, 3) != 0) ? $urandom_range(0, plan_w - 1) : $urandom;
      syv = ($urandom_range(0, 3) != 0) ? $urandom_range(0, plan_h - 1) : $urandom;
      add_cfg(ogrc_pkg::REG_SENSOR_X, 16'(sxv));
      add_cfg(ogrc_pkg::REG_SENSOR_Y, 16'(syv));
      free_raw = 8'($urandom);
      add_cfg(ogrc_pkg::REG_FREE, {8'($urandom), free_raw});
      if ($urandom_range(0, 7) == 0) add_cfg(ogrc_pkg::REG_OCCUPIED, {8'($urandom), free_raw});
      else add_cfg(ogrc_pkg::REG_OCCUPIED, 16'($urandom));
      add_cfg(ogrc_pkg::REG_UNKNOWN, 16'($urandom));

      for (k = 0; k < n_items; k++) begin
        if (phase == 8 && k == n_items / 2) begin
          add_req(ogrc_pkg::MODE_CLEAR, $urandom, $urandom);
          random_items++;
        end
        if (k == n_items / 2 && $urandom_range(0, 2) == 0) add_drain();
        tx = $urandom_range(0, plan_w - 1);
        ty = $urandom_range(0, plan_h - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          add_req(ogrc_pkg::MODE_RAY, tx, ty);
          random_items++;
        end else if (pick < 65) begin
          // Targets just past each edge, or anywhere in the coordinate range.
          case ($urandom_range(0, 4))
            0: tx = plan_w + $urandom_range(0, 3);
            1: tx = -1 - $urandom_range(0, 3);
            2: ty = plan_h + $urandom_range(0, 3);
            3: ty = -1 - $urandom_range(0, 3);
            default: begin
              tx = $urandom;
              ty = $urandom;
            end
          endcase
          add_req(ogrc_pkg::MODE_RAY, tx, ty);
          random_items++;
        end else if (pick < 97) begin
          if ($urandom_range(0, 6) == 0) begin
            tx = $urandom;
            ty = $urandom;
          end
          add_req(ogrc_pkg::MODE_READ, tx, ty);
          random_items++;
        end else begin
          add_req(MODE_UNUSED, $urandom, $urandom);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the driver's updates have settled.
    while (request_queue.size() != 0 || start) @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
